// ----- design/plps_pkg.sv -----
package plps_pkg;

    localparam int unsigned SLOTS       = 4;
    localparam int unsigned X_W         = 9;
    localparam int unsigned Y_W         = 8;
    localparam int unsigned POS_W       = X_W + Y_W;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned N_W         = 19;
    localparam int unsigned Q_W         = 32;
    localparam int unsigned ROOT_W      = Q_W / 2;
    localparam int unsigned REM_W       = ROOT_W + 2;
    localparam int unsigned W_W         = 18;
    localparam int unsigned PROD_W      = GAIN_W + W_W;
    localparam int unsigned SUM_W       = PROD_W + 2;
    localparam int unsigned SUM_SHIFT   = 16;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned LATENCY     = 2 + Q_W + ROOT_W + 2;

    localparam logic [Q_W-1:0]     FULL_SQUARE = 32'hFFFE_0001;
    localparam logic [W_W-1:0]     ZERO_WEIGHT = 18'd218450;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL   = 8'd255;

    localparam logic [IDX_W-1:0]   CFG_POS_BASE  = 4'd0;
    localparam logic [IDX_W-1:0]   CFG_GAIN_BASE = 4'd4;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [GAIN_W-1:0] gain;
    } t_light;

endpackage

// ----- design/point_light_pixel_shader_unit.sv -----
// An accepted pixel passes the distance, divider, root, product and level registers to the output.
// Throughput: one pixel per cycle unless stalled; one divider bit and one root bit per stage.
// A stalled output word freezes the whole pipeline in place.
// Reset (synchronous, active low) clears valid bits and the light registers.
module point_light_pixel_shader_unit
    import plps_pkg::*;
#(
    parameter int unsigned LIGHT_COUNT = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [X_W-1:0]       i_pixel_x,
    input  logic [Y_W-1:0]       i_pixel_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LEVEL_W-1:0]   o_pixel_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data
);

    t_light              r_light [0:LIGHT_COUNT-1];
    logic [PROD_W-1:0]   prod    [0:LIGHT_COUNT-1];
    logic                r_vld   [0:LATENCY-1];
    logic                en;
    logic [SUM_W-1:0]    sum;
    logic [LEVEL_W-1:0]  r_level;

    assign en          = !(r_vld[LATENCY-1] && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    for (genvar k = 0; k < LIGHT_COUNT; k++) begin : g_light
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_light[k] <= '0;
            end else if (i_cfg_valid) begin
                if (i_cfg_index == CFG_POS_BASE + IDX_W'(k)) begin
                    r_light[k].pos <= i_cfg_data;
                end
                if (i_cfg_index == CFG_GAIN_BASE + IDX_W'(k)) begin
                    r_light[k].gain <= i_cfg_data[GAIN_W-1:0];
                end
            end
        end

        plps_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_pixel_x (i_pixel_x),
            .i_pixel_y (i_pixel_y),
            .i_light   (r_light[k]),
            .o_prod    (prod[k])
        );
    end

    for (genvar s = 0; s < LATENCY; s++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < LIGHT_COUNT; k++) begin
            sum = sum + {2'b00, prod[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_level <= (sum[SUM_W-1:SUM_SHIFT+LEVEL_W] != '0) ? MAX_LEVEL
                                                             : sum[SUM_SHIFT +: LEVEL_W];
        end
    end

    assign o_valid       = r_vld[LATENCY-1];
    assign o_pixel_value = r_level;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall raised without an output word");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0]) else $error("accepted word not in pipeline");

    a_frozen_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_level) && o_valid) else $error("held word changed");

endmodule

// ----- design/plps_div.sv -----
module plps_div
    import plps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [N_W-1:0]   i_n,
    output logic [Q_W-1:0]   o_q,
    output logic             o_zero
);

    logic [N_W-1:0] r_rem  [0:Q_W-1];
    logic [Q_W-1:0] r_q    [0:Q_W-1];
    logic [N_W-1:0] r_n    [0:Q_W-1];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic [N_W-1:0] rem_p;
        logic [Q_W-1:0] q_p;
        logic [N_W-1:0] n_p;
        logic [N_W:0]   sh;
        logic [N_W:0]   diff;
        if (g == 0) begin : g_first
            assign rem_p = '0;
            assign q_p   = '0;
            assign n_p   = i_n;
        end else begin : g_next
            assign rem_p = r_rem[g-1];
            assign q_p   = r_q[g-1];
            assign n_p   = r_n[g-1];
        end
        assign sh   = {rem_p, FULL_SQUARE[Q_W-1-g]};
        assign diff = sh - {1'b0, n_p};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g] <= n_p;
                if (sh >= {1'b0, n_p}) begin
                    r_rem[g] <= diff[N_W-1:0];
                    r_q[g]   <= q_p | ({1'b1, {(Q_W-1){1'b0}}} >> g);
                end else begin
                    r_rem[g] <= sh[N_W-1:0];
                    r_q[g]   <= q_p;
                end
            end
        end
    end

    assign o_q    = r_q[Q_W-1];
    assign o_zero = (r_n[Q_W-1] == '0);

endmodule

// ----- design/plps_sqrt.sv -----
module plps_sqrt
    import plps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [Q_W-1:0]    i_v,
    input  logic              i_zero,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_zero
);

    logic [Q_W-1:0]    r_v    [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic              r_zero [0:ROOT_W-1];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [Q_W-1:0]    v_p;
        logic [ROOT_W-1:0] root_p;
        logic [REM_W-1:0]  rem_p;
        logic              zero_p;
        logic [REM_W+1:0]  sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        if (g == 0) begin : g_first
            assign v_p    = i_v;
            assign root_p = '0;
            assign rem_p  = '0;
            assign zero_p = i_zero;
        end else begin : g_next
            assign v_p    = r_v[g-1];
            assign root_p = r_root[g-1];
            assign rem_p  = r_rem[g-1];
            assign zero_p = r_zero[g-1];
        end
        assign sh    = {rem_p, v_p[Q_W-1-2*g -: 2]};
        assign trial = {2'b00, root_p, 2'b01};
        assign diff  = sh - trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g]    <= v_p;
                r_zero[g] <= zero_p;
                if (sh >= trial) begin
                    r_rem[g]  <= diff[REM_W-1:0];
                    r_root[g] <= {root_p[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= sh[REM_W-1:0];
                    r_root[g] <= {root_p[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_zero = r_zero[ROOT_W-1] && (r_v[ROOT_W-1] != '0) && (r_rem[ROOT_W-1] != '1);

endmodule

// ----- design/plps_lane.sv -----
module plps_lane
    import plps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [X_W-1:0]    i_pixel_x,
    input  logic [Y_W-1:0]    i_pixel_y,
    input  t_light            i_light,
    output logic [PROD_W-1:0] o_prod
);

    logic [X_W-1:0]    lx;
    logic [Y_W-1:0]    ly;
    logic [X_W-1:0]    r_dx;
    logic [Y_W-1:0]    r_dy;
    logic [N_W-1:0]    r_n;
    logic [Q_W-1:0]    q;
    logic              q_zero;
    logic [ROOT_W-1:0] root;
    logic              root_zero;
    logic [W_W-1:0]    weight;
    logic [PROD_W-1:0] r_prod;

    assign lx = i_light.pos[X_W-1:0];
    assign ly = i_light.pos[POS_W-1:X_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= (i_pixel_x > lx) ? i_pixel_x - lx : lx - i_pixel_x;
            r_dy <= (i_pixel_y > ly) ? i_pixel_y - ly : ly - i_pixel_y;
            r_n  <= N_W'({10'd0, r_dx} * {10'd0, r_dx}) + N_W'({11'd0, r_dy} * {11'd0, r_dy});
        end
    end

    plps_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_n    (r_n),
        .o_q    (q),
        .o_zero (q_zero)
    );

    plps_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_v    (q),
        .i_zero (q_zero),
        .o_root (root),
        .o_zero (root_zero)
    );

    assign weight = root_zero ? ZERO_WEIGHT : {{(W_W-ROOT_W){1'b0}}, root};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{W_W{1'b0}}, i_light.gain} * {{GAIN_W{1'b0}}, weight};
        end
    end

    assign o_prod = r_prod;

endmodule
